// ===== rtl/cscf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cscf_pkg: shared types and constants of the send-on-change transmit filter
// Field widths, reason and request codes, the table entry layout and the
// control state encoding.
// ----------------------------------------------------------------------------
package cscf_pkg;

    localparam int ID_W       = 11;
    localparam int DATA_W     = 64;
    localparam int LEN_W      = 4;
    localparam int TIME_W     = 32;
    localparam int REASON_W   = 3;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;

    localparam int ID_COUNT_DEFAULT = 2048;

    localparam logic [TIME_W-1:0] RESET_MIN_US = TIME_W'(25000);
    localparam logic [TIME_W-1:0] RESET_MAX_US = TIME_W'(125000);

    localparam logic REQ_OFFER   = 1'b0;
    localparam logic REQ_PROGRAM = 1'b1;

    localparam logic REG_DEFAULT_MIN = 1'b0;
    localparam logic REG_DEFAULT_MAX = 1'b1;

    localparam logic [REASON_W-1:0] R_SUPPRESSED = 3'd0;
    localparam logic [REASON_W-1:0] R_FIRST_SEEN = 3'd1;
    localparam logic [REASON_W-1:0] R_CHANGED    = 3'd2;
    localparam logic [REASON_W-1:0] R_HEARTBEAT  = 3'd3;
    localparam logic [REASON_W-1:0] R_PROGRAMMED = 3'd4;

    typedef struct packed {
        logic              valid;
        logic [DATA_W-1:0] data;
        logic [TIME_W-1:0] stamp;
        logic [TIME_W-1:0] min_us;
        logic [TIME_W-1:0] max_us;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic                wr_en;
        logic                send_now;
        logic [REASON_W-1:0] reason;
    } t_decision;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK
    } t_state;

endpackage

// ===== rtl/cscf_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cscf_ram: generic single-write, single-read synchronous RAM
// One write port and one read port with the read data registered.
// ----------------------------------------------------------------------------
module cscf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/cscf_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cscf_cfg: configuration registers
// APB-style access to the default minimum and maximum intervals that are
// given to an identifier seen for the first time.
// ----------------------------------------------------------------------------
module cscf_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cscf_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [cscf_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [cscf_pkg::CFG_DATA_W-1:0] prdata,
    output logic                        pready,
    output logic [cscf_pkg::TIME_W-1:0]  o_default_min,
    output logic [cscf_pkg::TIME_W-1:0]  o_default_max
);

    import cscf_pkg::*;

    logic              wr_stb;
    logic              reg_sel;
    logic [TIME_W-1:0] r_default_min;
    logic [TIME_W-1:0] r_default_max;

    assign pready  = 1'b1;
    assign wr_stb  = psel & penable & pwrite & pready;
    assign reg_sel = paddr[CFG_ADDR_W-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default_min <= RESET_MIN_US;
            r_default_max <= RESET_MAX_US;
        end else if (wr_stb) begin
            case (reg_sel)
                REG_DEFAULT_MIN: r_default_min <= pwdata;
                REG_DEFAULT_MAX: r_default_max <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_DEFAULT_MIN: prdata = r_default_min;
            REG_DEFAULT_MAX: prdata = r_default_max;
            default:         prdata = '0;
        endcase
    end

    assign o_default_min = r_default_min;
    assign o_default_max = r_default_max;

endmodule

// ===== rtl/cscf_decide.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cscf_decide: pass/suppress decision and entry update
// Takes the entry read from the table and the held request, and gives the
// decision together with the entry to be written back.
// ----------------------------------------------------------------------------
module cscf_decide #(
    parameter int ID_COUNT = cscf_pkg::ID_COUNT_DEFAULT
) (
    input  cscf_pkg::t_entry                i_rd_entry,
    input  logic                            i_req_type,
    input  logic [cscf_pkg::ID_W-1:0]       i_msg_id,
    input  logic [cscf_pkg::DATA_W-1:0]     i_msg_data,
    input  logic [cscf_pkg::TIME_W-1:0]     i_now_us,
    input  logic [cscf_pkg::TIME_W-1:0]     i_set_min_us,
    input  logic [cscf_pkg::TIME_W-1:0]     i_set_max_us,
    input  logic [cscf_pkg::TIME_W-1:0]     i_default_min,
    input  logic [cscf_pkg::TIME_W-1:0]     i_default_max,
    output cscf_pkg::t_decision             o_decision,
    output cscf_pkg::t_entry                o_wr_entry
);

    import cscf_pkg::*;

    logic              in_range;
    logic              changed;
    logic [TIME_W-1:0] elapsed;

    assign in_range = {1'b0, i_msg_id} < (ID_W + 1)'(ID_COUNT);
    assign elapsed  = i_now_us - i_rd_entry.stamp;
    assign changed  = i_msg_data != i_rd_entry.data;

    always_comb begin
        o_wr_entry = i_rd_entry;
        o_decision = '0;
        o_decision.reason = R_SUPPRESSED;
        if (in_range) begin
            if (i_req_type == REQ_PROGRAM) begin
                if (!i_rd_entry.valid) begin
                    o_wr_entry.valid = 1'b1;
                    o_wr_entry.data  = '0;
                    o_wr_entry.stamp = i_now_us;
                end
                o_wr_entry.min_us = i_set_min_us;
                o_wr_entry.max_us = i_set_max_us;
                o_decision.reason = R_PROGRAMMED;
                o_decision.wr_en  = 1'b1;
            end else if (!i_rd_entry.valid) begin
                o_wr_entry.valid    = 1'b1;
                o_wr_entry.min_us   = i_default_min;
                o_wr_entry.max_us   = i_default_max;
                o_decision.send_now = 1'b1;
                o_decision.reason   = R_FIRST_SEEN;
            end else if (changed && (elapsed >= i_rd_entry.min_us)) begin
                o_decision.send_now = 1'b1;
                o_decision.reason   = R_CHANGED;
            end else if (!changed && (elapsed >= i_rd_entry.max_us)) begin
                o_decision.send_now = 1'b1;
                o_decision.reason   = R_HEARTBEAT;
            end
            if (o_decision.send_now) begin
                o_wr_entry.data  = i_msg_data;
                o_wr_entry.stamp = i_now_us;
                o_decision.wr_en = 1'b1;
            end
        end
    end

endmodule

// ===== rtl/can_send_on_change_filter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// can_send_on_change_filter_top: per-identifier send-on-change CAN filter
// Decides for each offered frame whether it is sent, and loads per-entry
// resend intervals on program requests.
// ----------------------------------------------------------------------------
// Each request reads its identifier's table entry from the single-port-pair
// entry RAM in the idle state, then is decided and written back in the
// lookup state, where it waits while the output register holds an untaken
// result; a new request is accepted only after that, and the result waits in
// an output register until it is taken. After reset the block runs a clearing
// pass over all ID_COUNT entries (2048 by default) that marks every entry
// unseen, during which no request is accepted; configuration writes are taken throughout.
module can_send_on_change_filter_top #(
    parameter int ID_COUNT = cscf_pkg::ID_COUNT_DEFAULT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [cscf_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [cscf_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [cscf_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_req_type,
    input  logic [cscf_pkg::ID_W-1:0]       i_msg_id,
    input  logic [cscf_pkg::DATA_W-1:0]     i_msg_data,
    input  logic [cscf_pkg::LEN_W-1:0]      i_msg_length,
    input  logic [cscf_pkg::TIME_W-1:0]     i_now_us,
    input  logic [cscf_pkg::TIME_W-1:0]     i_set_min_us,
    input  logic [cscf_pkg::TIME_W-1:0]     i_set_max_us,
    input  logic                            i_batch_end,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_send_now,
    output logic [cscf_pkg::ID_W-1:0]       o_out_id,
    output logic [cscf_pkg::DATA_W-1:0]     o_out_data,
    output logic [cscf_pkg::LEN_W-1:0]      o_out_length,
    output logic [cscf_pkg::REASON_W-1:0]   o_reason,
    output logic                            o_batch_end_out
);

    import cscf_pkg::*;

    localparam int ADDR_W = $clog2(ID_COUNT);

    t_state              r_state;
    t_state              n_state;
    logic [ADDR_W-1:0]   r_clr_addr;
    logic [ADDR_W-1:0]   n_clr_addr;
    logic                clr_last;
    logic                in_xfer;
    logic                out_free;
    logic                load_out;

    logic                r_req_type;
    logic [ID_W-1:0]     r_msg_id;
    logic [DATA_W-1:0]   r_msg_data;
    logic [LEN_W-1:0]    r_msg_length;
    logic [TIME_W-1:0]   r_now_us;
    logic [TIME_W-1:0]   r_set_min_us;
    logic [TIME_W-1:0]   r_set_max_us;
    logic                r_batch_end;

    logic                r_out_valid;
    logic                n_out_valid;
    logic                r_send_now;
    logic [ID_W-1:0]     r_out_id;
    logic [DATA_W-1:0]   r_out_data;
    logic [LEN_W-1:0]    r_out_length;
    logic [REASON_W-1:0] r_reason;
    logic                r_batch_end_out;

    logic [TIME_W-1:0]   default_min;
    logic [TIME_W-1:0]   default_max;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0]  ram_wdata;
    logic                ram_re;
    logic [ENTRY_W-1:0]  ram_rdata;
    t_entry              rd_entry;
    t_entry              wr_entry;
    t_decision           decision;

    cscf_cfg u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_default_min (default_min),
        .o_default_max (default_max)
    );

    cscf_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ID_COUNT)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (i_msg_id[ADDR_W-1:0]),
        .o_rdata (ram_rdata)
    );

    assign rd_entry = t_entry'(ram_rdata);

    cscf_decide #(
        .ID_COUNT (ID_COUNT)
    ) u_decide (
        .i_rd_entry    (rd_entry),
        .i_req_type    (r_req_type),
        .i_msg_id      (r_msg_id),
        .i_msg_data    (r_msg_data),
        .i_now_us      (r_now_us),
        .i_set_min_us  (r_set_min_us),
        .i_set_max_us  (r_set_max_us),
        .i_default_min (default_min),
        .i_default_max (default_max),
        .o_decision    (decision),
        .o_wr_entry    (wr_entry)
    );

    assign clr_last = r_clr_addr == ADDR_W'(ID_COUNT - 1);
    assign out_free = !r_out_valid || i_out_ready;
    assign in_xfer  = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_LOOK;
                end
            end
            ST_LOOK: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        ram_re     = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = r_msg_id[ADDR_W-1:0];
        ram_wdata  = wr_entry;
        load_out   = 1'b0;
        n_clr_addr = r_clr_addr;
        case (r_state)
            ST_CLEAR: begin
                ram_we     = 1'b1;
                ram_waddr  = r_clr_addr;
                ram_wdata  = '0;
                n_clr_addr = r_clr_addr + 1'b1;
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                ram_re     = i_in_valid;
            end
            ST_LOOK: begin
                load_out = out_free;
                ram_we   = out_free && decision.wr_en;
            end
            default: ;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_req_type   <= i_req_type;
            r_msg_id     <= i_msg_id;
            r_msg_data   <= i_msg_data;
            r_msg_length <= i_msg_length;
            r_now_us     <= i_now_us;
            r_set_min_us <= i_set_min_us;
            r_set_max_us <= i_set_max_us;
            r_batch_end  <= i_batch_end;
        end
        if (load_out) begin
            r_send_now      <= decision.send_now;
            r_out_id        <= r_msg_id;
            r_out_data      <= r_msg_data;
            r_out_length    <= r_msg_length;
            r_reason        <= decision.reason;
            r_batch_end_out <= r_batch_end;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_send_now      = r_send_now;
    assign o_out_id        = r_out_id;
    assign o_out_data      = r_out_data;
    assign o_out_length    = r_out_length;
    assign o_reason        = r_reason;
    assign o_batch_end_out = r_batch_end_out;

`ifndef SYNTHESIS
    a_accept_to_look: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> r_state == ST_LOOK)
        else $error("Accepted transfer did not move to the lookup state.");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_IDLE |-> !ram_we)
        else $error("Entry table written while idle.");

    a_send_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_send_now) |->
            (o_reason == R_FIRST_SEEN || o_reason == R_CHANGED
             || o_reason == R_HEARTBEAT))
        else $error("Frame sent with a reason that does not allow it.");

    a_program_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load_out && decision.reason == R_PROGRAMMED) |-> ram_we)
        else $error("Program request did not update its entry.");
`endif

endmodule
